/* rtl/text_console_cursor_engine_top_defines.svh */
// Assertion macros for the console checker
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Check a property every clock while out of reset
`define TCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property including reset cycles
`define TCC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tcc_pkg.sv */
// Shared types and codes for the text console cursor engine
package tcc_pkg;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // Classified command word passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [7:0]  delta_col;
        logic [7:0]  delta_row;
        logic [10:0] cell_index;
    } cmd_t;

endpackage

/* rtl/text_console_cursor_engine_top.sv */
// A put or move passes from the queue through EXEC and DONE; a read passes
// through EXEC, READ and DONE. A put that scrolls copies each cell up a row,
// reading then writing each, then fills the last row; clear fills every cell.
// The back end takes a new command only once the last one is done.
// A two-word queue holds commands; busy rises when it is full.
// Reset clears cursor, queue and attribute; screen memory is not cleared.
module text_console_cursor_engine_top
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_code,
    input  logic signed [7:0] delta_col,
    input  logic signed [7:0] delta_row,
    input  logic [10:0] cell_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_linear,
    output logic [15:0] cell_value
);

    logic [7:0] attribute_reg;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            attribute_reg <= cfg_data;
        end
    end

    tcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .char_code  (char_code),
        .delta_col  (delta_col),
        .delta_row  (delta_row),
        .cell_index (cell_index),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .attribute     (attribute_reg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .done          (done),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_linear (cursor_linear),
        .cell_value    (cell_value)
    );

endmodule

/* rtl/tcc_front.sv */
// Command front end: accept words and queue them for the back end
module tcc_front
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_code,
    input  logic [7:0]  delta_col,
    input  logic [7:0]  delta_row,
    input  logic [10:0] cell_index,
    output logic        busy,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    // Two-entry queue
    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       in_cmd;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.kind       = kind_t'(kind);
        in_cmd.char_code  = char_code;
        in_cmd.delta_col  = delta_col;
        in_cmd.delta_row  = delta_row;
        in_cmd.cell_index = cell_index;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/tcc_back.sv */
// Command back end: cursor, screen memory, scroll and clear sequencer
module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  attribute,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        done,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_linear,
    output logic [15:0] cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 8);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int SCROLL_CELLS = CELLS - COLUMNS;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_SCRD   = 7'b0000100,
        ST_SCWR   = 7'b0001000,
        ST_FILL   = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [15:0]   rd_data_reg;
    logic          rd_hit_reg, rd_hit_next;
    logic [15:0]   cell_out_reg, cell_out_next;
    logic          done_reg, done_next;
    logic [6:0]    out_col_reg;
    logic [4:0]    out_row_reg;
    logic [10:0]   out_lin_reg;

    logic [15:0]   mem [CELLS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Cursor arithmetic, wide enough for signed offsets
    logic signed [9:0] mx, my;
    logic [CW:0]       tab_col;
    logic [AW-1:0]     lin_calc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign lin_calc = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ptr_next      = ptr_reg;
        rd_hit_next   = rd_hit_reg;
        cell_out_next = cell_out_reg;
        done_next     = 1'b0;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = {attribute, CH_SPACE};
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg;
        mx            = '0;
        my            = '0;
        tab_col       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cell_out_next = '0;
                state_next = ST_DONE;
                case (cmd_reg.kind)
                    KIND_PUT:
                    begin
                        if (cmd_reg.char_code == CH_BS)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                        end
                        else if (cmd_reg.char_code == CH_TAB)
                        begin
                            tab_col  = {1'b0, col_reg} + (CW+1)'(8);
                            col_next = CW'({tab_col[CW:3], 3'b000});
                        end
                        else if (cmd_reg.char_code == CH_CR)
                        begin
                            col_next = '0;
                        end
                        else if (cmd_reg.char_code == CH_LF)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else if (cmd_reg.char_code >= CH_SPACE && !cmd_reg.char_code[7])
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = lin_calc;
                            mem_wdata = {attribute, cmd_reg.char_code};
                            col_next  = col_reg + 1'b1;
                        end
                        if (col_next >= CW'(COLUMNS))
                        begin
                            col_next = '0;
                            row_next = row_next + 1'b1;
                        end
                        if (row_next >= RW'(ROWS))
                        begin
                            row_next   = RW'(ROWS - 1);
                            ptr_next   = '0;
                            state_next = ST_SCRD;
                        end
                    end
                    KIND_MOVE:
                    begin
                        mx = 10'(col_reg) + 10'(signed'(cmd_reg.delta_col));
                        my = 10'(row_reg) + 10'(signed'(cmd_reg.delta_row));
                        if (mx < 0)
                        begin
                            if (my > 0)
                            begin
                                my = my - 10'sd1;
                                mx = 10'(COLUMNS - 1);
                            end
                            else
                            begin
                                mx = '0;
                            end
                        end
                        if (mx >= 10'(COLUMNS))
                        begin
                            if (my < 10'(ROWS - 1))
                            begin
                                mx = '0;
                                my = my + 10'sd1;
                            end
                            else
                            begin
                                mx = 10'(COLUMNS - 1);
                            end
                        end
                        if (my < 0)
                        begin
                            my = '0;
                        end
                        if (my >= 10'(ROWS))
                        begin
                            my = 10'(ROWS - 1);
                        end
                        col_next = CW'(mx);
                        row_next = RW'(my);
                    end
                    KIND_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        ptr_next   = '0;
                        state_next = ST_FILL;
                    end
                    KIND_READ:
                    begin
                        rd_hit_next = ({1'b0, cmd_reg.cell_index} < 12'(CELLS));
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(cmd_reg.cell_index);
                        state_next  = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCRD:
            begin
                // fetch the cell one row below
                mem_re     = 1'b1;
                mem_raddr  = AW'({1'b0, ptr_reg} + (AW+1)'(COLUMNS));
                state_next = ST_SCWR;
            end
            ST_SCWR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if ({1'b0, ptr_reg} == (AW+1)'(SCROLL_CELLS - 1))
                begin
                    ptr_next   = AW'(SCROLL_CELLS);
                    state_next = ST_FILL;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SCRD;
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if ({1'b0, ptr_reg} == (AW+1)'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                cell_out_next = rd_hit_reg ? rd_data_reg : 16'h0000;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ptr_reg      <= ptr_next;
        rd_hit_reg   <= rd_hit_next;
        cell_out_reg <= cell_out_next;
        if (state_reg == ST_DONE)
        begin
            out_col_reg <= 7'(col_reg);
            out_row_reg <= 5'(row_reg);
            out_lin_reg <= 11'(lin_calc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
        end
    end

    assign done          = done_reg;
    assign cursor_col    = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_linear = out_lin_reg;
    assign cell_value    = done_reg ? cell_out_reg : 16'h0000;

endmodule

/* rtl/tcc_checker.sv */
// Port-level checker for the text console cursor engine
`include "text_console_cursor_engine_top_defines.svh"

module tcc_checker
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [6:0]  cursor_col,
    input logic [4:0]  cursor_row,
    input logic [10:0] cursor_linear
);

    `TCC_ASSERT(a_col_range, done |-> int'(cursor_col) < COLUMNS, "cursor column out of range")
    `TCC_ASSERT(a_row_range, done |-> int'(cursor_row) < ROWS, "cursor row out of range")
    `TCC_ASSERT(a_linear, done |-> cursor_linear == 11'(cursor_row * COLUMNS + cursor_col), "linear mismatch")
    `TCC_ASSERT(a_done_pulse, done |=> !done, "done held for two cycles")
    `TCC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done && !busy, "activity during reset")

endmodule

bind text_console_cursor_engine_top tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .done          (done),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_linear (cursor_linear)
);
